// ----- design/dwo_pkg.sv -----
// Shared types, constants and table functions for the decimated wavetable oscillator.
`timescale 1ns / 1ps
package dwo_pkg;

    localparam int unsigned KIND_W    = 2;
    localparam int unsigned FREQ_W    = 20;
    localparam int unsigned ADDR_W    = 11;
    localparam int unsigned SAMPLE_W  = 12;
    localparam int unsigned PERIOD_W  = 21;
    localparam int unsigned PHASE_W   = 10;
    localparam int unsigned LEVEL_W   = 3;
    localparam int unsigned STORE_DEPTH = 1170;

    localparam int unsigned DIV_NUM_W = 24;
    localparam int unsigned DIV_DEN_W = 17;

    localparam int unsigned RECIP_W     = 23;
    localparam int unsigned RECIP_SHIFT = 26;

    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 40;

    localparam logic [KIND_W-1:0] KIND_FREQ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

    localparam logic [DIV_NUM_W-1:0] CLOCK_NUMERATOR = 24'd10500000;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 21'd1050;
    localparam logic [SAMPLE_W-1:0] SAMPLE_RESET = 12'd2000;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_rsp;

    function automatic logic [PHASE_W-1:0] level_length(input logic [LEVEL_W-1:0] lvl);
        case (lvl)
            3'd0:    level_length = 10'd600;
            3'd1:    level_length = 10'd300;
            3'd2:    level_length = 10'd150;
            3'd3:    level_length = 10'd75;
            3'd4:    level_length = 10'd25;
            3'd5:    level_length = 10'd15;
            default: level_length = 10'd5;
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] level_base(input logic [LEVEL_W-1:0] lvl);
        case (lvl)
            3'd0:    level_base = 11'd0;
            3'd1:    level_base = 11'd600;
            3'd2:    level_base = 11'd900;
            3'd3:    level_base = 11'd1050;
            3'd4:    level_base = 11'd1125;
            3'd5:    level_base = 11'd1150;
            default: level_base = 11'd1165;
        endcase
    endfunction

    function automatic logic [LEVEL_W-1:0] level_of(input logic [FREQ_W-1:0] f);
        if (f < 20'd3300) begin
            level_of = 3'd0;
        end else if (f < 20'd6600) begin
            level_of = 3'd1;
        end else if (f < 20'd20000) begin
            level_of = 3'd2;
        end else if (f < 20'd53300) begin
            level_of = 3'd3;
        end else if (f < 20'd160000) begin
            level_of = 3'd4;
        end else if (f < 20'd266600) begin
            level_of = 3'd5;
        end else begin
            level_of = 3'd6;
        end
    endfunction

    // Reciprocal of the pre-scale divisor 10, 100 or 20, scaled by 2**RECIP_SHIFT and rounded
    // up, which is exact over each level's frequency range; zero when the level needs none.
    function automatic logic [RECIP_W-1:0] prescale_recip(input logic [LEVEL_W-1:0] lvl);
        case (lvl)
            3'd2:    prescale_recip = 23'd6710887;
            3'd3:    prescale_recip = 23'd671089;
            3'd5:    prescale_recip = 23'd671089;
            3'd6:    prescale_recip = 23'd3355444;
            default: prescale_recip = 23'd0;
        endcase
    endfunction

    function automatic logic [6:0] prescale_mul(input logic [LEVEL_W-1:0] lvl);
        case (lvl)
            3'd2:    prescale_mul = 7'd15;
            3'd3:    prescale_mul = 7'd75;
            3'd5:    prescale_mul = 7'd15;
            default: prescale_mul = 7'd1;
        endcase
    endfunction

endpackage

// ----- design/dwo_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module dwo_ram #(
    parameter int unsigned WIDTH = 12,
    parameter int unsigned DEPTH = 1170,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/dwo_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module dwo_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dwo_pkg::t_div_req i_req,
    output dwo_pkg::t_div_rsp o_rsp
);

    localparam int unsigned NW = dwo_pkg::DIV_NUM_W;
    localparam int unsigned DW = dwo_pkg::DIV_DEN_W;
    localparam int unsigned CW = $clog2(NW);
    localparam logic [CW-1:0] LAST = CW'(NW - 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;

    logic [DW:0]   n_shift;
    logic          n_ge;
    logic [DW:0]   n_diff;

    always_comb begin
        n_shift = {r_rem, r_q[NW-1]};
        n_ge    = (n_shift >= {1'b0, r_den});
        n_diff  = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_rem <= n_ge ? n_diff[DW-1:0] : n_shift[DW-1:0];
                r_q   <= {r_q[NW-2:0], n_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_q    <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

// ----- design/decimated_wavetable_oscillator.sv -----
// Top level of the decimated wavetable oscillator: sequencer, state and stream ports.
`timescale 1ns / 1ps
// A sample tick beat moves to S_TICK, which registers its result beat and returns to
// S_IDLE; a tick waits in S_TICK only while an earlier result beat is still held.
// A table write beat is taken in S_IDLE, and a beat of unknown kind is dropped there.
// A frequency beat holds the input until the radix-2 divider is done; a pre-scale by 10,
// 20 or 100 runs first by reciprocal multiplication, ahead of the shared divider.
// Reset clears phase and levels and sets periods and the held sample to their reset
// values; the wave store is not cleared and must be written before it is read.
module decimated_wavetable_oscillator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // frequency_x100[19:0], table_address[30:20], table_value[42:31], zero fill.
    input  logic [dwo_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // kind[1:0].
    input  logic [dwo_pkg::KIND_W-1:0]       i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // sample[11:0], timer_period[32:12], period_updated[33], zero fill.
    output logic [dwo_pkg::M_TDATA_W-1:0]    o_m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_SCALE,
        S_MAIN,
        S_TICK
    } t_state;

    localparam int unsigned FW = dwo_pkg::FREQ_W;
    localparam int unsigned AW = dwo_pkg::ADDR_W;
    localparam int unsigned SW = dwo_pkg::SAMPLE_W;
    localparam int unsigned PW = dwo_pkg::PERIOD_W;
    localparam int unsigned HW = dwo_pkg::PHASE_W;
    localparam int unsigned LW = dwo_pkg::LEVEL_W;
    localparam int unsigned DW = dwo_pkg::DIV_DEN_W;
    localparam int unsigned RW = dwo_pkg::RECIP_W;

    t_state        r_state;
    logic [HW-1:0] r_phase;
    logic [LW-1:0] r_act_lvl;
    logic [LW-1:0] r_pend_lvl;
    logic [PW-1:0] r_act_period;
    logic [PW-1:0] r_pend_period;
    logic [SW-1:0] r_cur_sample;
    logic [SW-1:0] r_emit;
    logic          r_upd;
    logic          r_out_valid;
    logic [SW-1:0] r_out_sample;
    logic [PW-1:0] r_out_period;
    logic          r_out_upd;
    logic [FW-1:0] r_freq;
    logic [DW-1:0] r_pre_q;

    logic             n_accept;
    logic [FW-1:0]    n_freq;
    logic [AW-1:0]    n_addr;
    logic [SW-1:0]    n_value;
    logic [FW-1:0]    n_f1;
    logic [LW-1:0]    n_lvl;
    logic             n_need_pre;
    logic [RW-1:0]    n_pre_recip;
    logic [FW+RW-1:0] n_pre_prod;
    logic [DW-1:0]    n_pre_q;
    logic [DW-1:0]    n_direct_den;
    logic [DW-1:0]    n_scaled;
    logic [DW-1:0]    n_main_den;
    logic             n_adopt;
    logic [LW-1:0]    n_tick_lvl;
    logic [PW-1:0]    n_tick_period;
    logic [HW-1:0]    n_len;
    logic [HW-1:0]    n_phase_inc;
    logic [HW-1:0]    n_phase;
    logic             n_we;
    logic             n_re;
    logic [AW-1:0]    n_raddr;
    logic [SW-1:0]    n_rdata;
    logic             n_out_free;

    dwo_pkg::t_div_req n_div_req;
    dwo_pkg::t_div_rsp n_div_rsp;

    assign o_s_tready = (r_state == S_IDLE);
    assign n_accept   = i_s_tvalid && o_s_tready;
    assign n_freq     = i_s_tdata[FW-1:0];
    assign n_addr     = i_s_tdata[FW+AW-1:FW];
    assign n_value    = i_s_tdata[FW+AW+SW-1:FW+AW];
    assign n_out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_f1       = (n_freq == '0) ? FW'(1) : n_freq;
        n_lvl      = dwo_pkg::level_of(n_f1);
        n_need_pre = (dwo_pkg::prescale_recip(n_lvl) != '0);
        case (n_lvl)
            3'd0:    n_direct_den = DW'(n_f1) * DW'(6);
            3'd1:    n_direct_den = DW'(n_f1) * DW'(3);
            default: n_direct_den = DW'(n_f1 >> 2);
        endcase
        n_pre_recip = dwo_pkg::prescale_recip(r_pend_lvl);
        n_pre_prod  = (FW+RW)'(r_freq) * (FW+RW)'(n_pre_recip);
        n_pre_q     = n_pre_prod[dwo_pkg::RECIP_SHIFT +: DW];
        n_scaled    = r_pre_q * DW'(dwo_pkg::prescale_mul(r_pend_lvl));
        n_main_den  = (r_state == S_SCALE) ? n_scaled : n_direct_den;
        if (n_main_den == '0) begin
            n_main_den = DW'(1);
        end

        n_adopt       = (r_phase == '0) && (r_pend_period != r_act_period);
        n_tick_lvl    = n_adopt ? r_pend_lvl : r_act_lvl;
        n_tick_period = n_adopt ? r_pend_period : r_act_period;
        n_len         = dwo_pkg::level_length(n_tick_lvl);
        n_phase_inc   = r_phase + 1'b1;
        n_phase       = (n_phase_inc >= n_len) ? '0 : n_phase_inc;
        n_raddr       = dwo_pkg::level_base(n_tick_lvl) + AW'(n_phase);

        n_we = n_accept && (i_s_tuser == dwo_pkg::KIND_WRITE)
               && (n_addr < AW'(dwo_pkg::STORE_DEPTH));
        n_re = n_accept && (i_s_tuser == dwo_pkg::KIND_TICK);

        n_div_req.start = 1'b0;
        n_div_req.num   = dwo_pkg::CLOCK_NUMERATOR;
        n_div_req.den   = n_main_den;
        if (n_accept && (i_s_tuser == dwo_pkg::KIND_FREQ) && !n_need_pre) begin
            n_div_req.start = 1'b1;
        end else if (r_state == S_SCALE) begin
            n_div_req.start = 1'b1;
        end
    end

    dwo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div_req),
        .o_rsp   (n_div_rsp)
    );

    dwo_ram #(
        .WIDTH (SW),
        .DEPTH (dwo_pkg::STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_addr),
        .i_wdata (n_value),
        .i_re    (n_re),
        .i_raddr (n_raddr),
        .o_rdata (n_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= '0;
            r_act_lvl     <= '0;
            r_pend_lvl    <= '0;
            r_act_period  <= dwo_pkg::PERIOD_RESET;
            r_pend_period <= dwo_pkg::PERIOD_RESET;
            r_cur_sample  <= dwo_pkg::SAMPLE_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && (r_state != S_TICK)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        case (i_s_tuser)
                            dwo_pkg::KIND_FREQ: begin
                                r_pend_lvl <= n_lvl;
                                r_freq     <= n_f1;
                                r_state    <= n_need_pre ? S_PRE : S_MAIN;
                            end
                            dwo_pkg::KIND_TICK: begin
                                r_emit       <= r_cur_sample;
                                r_upd        <= n_adopt;
                                r_act_lvl    <= n_tick_lvl;
                                r_act_period <= n_tick_period;
                                r_phase      <= n_phase;
                                r_state      <= S_TICK;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_PRE: begin
                    r_pre_q <= n_pre_q;
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_state <= S_MAIN;
                end
                S_MAIN: begin
                    if (n_div_rsp.done) begin
                        r_pend_period <= n_div_rsp.quot[PW-1:0];
                        r_state       <= S_IDLE;
                    end
                end
                S_TICK: begin
                    if (n_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= r_emit;
                        r_out_period <= r_act_period;
                        r_out_upd    <= r_upd;
                        r_cur_sample <= n_rdata;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(dwo_pkg::M_TDATA_W - SW - PW - 1){1'b0}},
                         r_out_upd, r_out_period, r_out_sample};

endmodule

// ----- test/decimated_wavetable_oscillator_tb.sv -----
// Self-checking stream testbench for the decimated wavetable oscillator with its own predictor.
`timescale 1ns / 1ps
module decimated_wavetable_oscillator_tb;
    import dwo_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned RESET_CYCLES = 11;
    localparam int unsigned MAX_GAP = 18;
    localparam int unsigned SETTLE_CYCLES = 80;
    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned FILL_W = S_TDATA_W - FREQ_W - ADDR_W - SAMPLE_W;
    localparam int unsigned UPD_BIT = SAMPLE_W + PERIOD_W;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [PERIOD_W-1:0] period;
        logic                updated;
    } t_tick_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata;
    logic [KIND_W-1:0]      i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [M_TDATA_W-1:0]   o_m_tdata;

    logic [PHASE_W-1:0]     osc_phase;
    logic [LEVEL_W-1:0]     active_lvl;
    logic [LEVEL_W-1:0]     pending_lvl;
    logic [PERIOD_W-1:0]    active_per;
    logic [PERIOD_W-1:0]    pending_per;
    logic [SAMPLE_W-1:0]    held_sample;
    logic [SAMPLE_W-1:0]    wave_mem [STORE_DEPTH];

    t_tick_result           expected_ticks [$];
    logic [FREQ_W-1:0]      last_freq;
    bit                     gaps_on;
    int unsigned            mismatches;
    int unsigned            ticks_seen;
    int unsigned            freq_sent;
    int unsigned            writes_sent;
    int unsigned            adoptions;
    int unsigned            useful_items;

    int unsigned level_edges [13] = '{266600, 266599, 160000, 96000, 159999, 53300, 53299,
                                      20000, 19999, 6600, 6599, 3300, 3299};

    decimated_wavetable_oscillator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned seg_len(input logic [LEVEL_W-1:0] lvl);
        case (lvl)
            3'd0:    return 600;
            3'd1:    return 300;
            3'd2:    return 150;
            3'd3:    return 75;
            3'd4:    return 25;
            3'd5:    return 15;
            default: return 5;
        endcase
    endfunction

    function automatic int unsigned seg_base(input logic [LEVEL_W-1:0] lvl);
        case (lvl)
            3'd0:    return 0;
            3'd1:    return 600;
            3'd2:    return 900;
            3'd3:    return 1050;
            3'd4:    return 1125;
            3'd5:    return 1150;
            default: return 1165;
        endcase
    endfunction

    function automatic void retune(input logic [FREQ_W-1:0] freq);
        int unsigned f;
        int unsigned den;
        f = (freq == '0) ? 1 : int'(freq);
        if (f < 3300) begin
            pending_lvl = 3'd0;
            den = f * 6;
        end else if (f < 6600) begin
            pending_lvl = 3'd1;
            den = f * 3;
        end else if (f < 20000) begin
            pending_lvl = 3'd2;
            den = (f / 10) * 15;
        end else if (f < 53300) begin
            pending_lvl = 3'd3;
            den = (f / 100) * 75;
        end else if (f < 160000) begin
            pending_lvl = 3'd4;
            den = f / 4;
        end else if (f < 266600) begin
            pending_lvl = 3'd5;
            den = (f / 100) * 15;
        end else begin
            pending_lvl = 3'd6;
            den = f / 20;
        end
        if (den == 0) den = 1;
        pending_per = PERIOD_W'(int'(CLOCK_NUMERATOR) / den);
    endfunction

    function automatic void advance_tick();
        t_tick_result r;
        r.sample  = held_sample;
        r.updated = 1'b0;
        if (osc_phase == '0 && pending_per != active_per) begin
            active_per = pending_per;
            active_lvl = pending_lvl;
            r.updated  = 1'b1;
            adoptions++;
        end
        r.period    = active_per;
        osc_phase   = PHASE_W'((int'(osc_phase) + 1) % seg_len(active_lvl));
        held_sample = wave_mem[seg_base(active_lvl) + int'(osc_phase)];
        expected_ticks.push_back(r);
    endfunction

    function automatic void predict_beat(input logic [KIND_W-1:0] kind,
                                         input logic [FREQ_W-1:0] freq,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic [SAMPLE_W-1:0] value);
        case (kind)
            KIND_FREQ: begin
                retune(freq);
                freq_sent++;
                useful_items++;
            end
            KIND_TICK: begin
                advance_tick();
                useful_items++;
            end
            KIND_WRITE: begin
                if (int'(addr) < STORE_DEPTH) begin
                    wave_mem[addr] = value;
                    writes_sent++;
                    useful_items++;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function automatic logic [FREQ_W-1:0] rand_frequency();
        int unsigned pick;
        int unsigned f;
        pick = $urandom_range(0, 15);
        if (pick == 0) f = $urandom_range(0, 3299);
        else if (pick == 1) f = $urandom_range(3300, 6599);
        else if (pick == 2) f = $urandom_range(6600, 19999);
        else if (pick <= 4) f = $urandom_range(20000, 53299);
        else if (pick <= 7) f = $urandom_range(53300, 159999);
        else if (pick <= 10) f = $urandom_range(160000, 266599);
        else f = $urandom_range(266600, 1048575);
        return FREQ_W'(f);
    endfunction

    task automatic send_beat(input logic [KIND_W-1:0] kind,
                             input logic [FREQ_W-1:0] freq,
                             input logic [ADDR_W-1:0] addr,
                             input logic [SAMPLE_W-1:0] value);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            @(negedge i_clk) i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {{FILL_W{1'b0}}, value, addr, freq};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        predict_beat(kind, freq, addr, value);
    endtask

    task automatic send_tick();
        send_beat(KIND_TICK, FREQ_W'($urandom), ADDR_W'($urandom), SAMPLE_W'($urandom));
    endtask

    task automatic send_frequency(input logic [FREQ_W-1:0] freq);
        last_freq = freq;
        send_beat(KIND_FREQ, freq, ADDR_W'($urandom), SAMPLE_W'($urandom));
    endtask

    task automatic send_write(input logic [ADDR_W-1:0] addr, input logic [SAMPLE_W-1:0] value);
        send_beat(KIND_WRITE, FREQ_W'($urandom), addr, value);
    endtask

    task automatic send_noise();
        if ($urandom_range(0, 1) == 0)
            send_beat(KIND_UNUSED, FREQ_W'($urandom), ADDR_W'($urandom), SAMPLE_W'($urandom));
        else
            send_write(ADDR_W'($urandom_range(STORE_DEPTH, 2047)), SAMPLE_W'($urandom));
    endtask

    // Ticks until the phase is back at zero, then one more tick where a change can take effect.
    task automatic tick_through_wrap();
        while (osc_phase != '0) send_tick();
        send_tick();
    endtask

    task automatic wait_all_results(input int unsigned settle);
        @(negedge i_clk) i_s_tvalid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic test_store_load();
        gaps_on = 1'b0;
        for (int a = 0; a < STORE_DEPTH; a++) begin
            if (a == 0) send_write(ADDR_W'(a), '0);
            else if (a == 1) send_write(ADDR_W'(a), '1);
            else send_write(ADDR_W'(a), SAMPLE_W'($urandom));
        end
        send_write(ADDR_W'(STORE_DEPTH), '1);
        send_write('1, '1);
        send_beat(KIND_UNUSED, '1, '1, '1);
        send_beat(KIND_UNUSED, '0, '0, '0);
    endtask

    task automatic test_zero_frequency();
        gaps_on = 1'b0;
        send_frequency(20'd1);
        send_tick();
        send_frequency('0);
        tick_through_wrap();
        send_frequency('1);
        tick_through_wrap();
    endtask

    task automatic test_level_boundaries();
        gaps_on = 1'b1;
        foreach (level_edges[i]) begin
            send_frequency(FREQ_W'(level_edges[i]));
            tick_through_wrap();
        end
        wait_all_results(2);
    endtask

    task automatic test_random_traffic();
        int unsigned goal;
        int unsigned choice;
        logic [FREQ_W-1:0] f;
        goal = useful_items + RANDOM_ITEMS;
        gaps_on = 1'b1;
        while (useful_items < goal) begin
            choice = $urandom_range(0, 19);
            if (choice < 12) begin
                f = ($urandom_range(0, 5) == 0) ? last_freq : rand_frequency();
                send_frequency(f);
                if (seg_len(active_lvl) <= 150 || $urandom_range(0, 7) == 0)
                    if ($urandom_range(0, 2) != 0) tick_through_wrap();
                repeat ($urandom_range(1, 30)) send_tick();
            end else if (choice < 15) begin
                repeat ($urandom_range(1, 8))
                    send_write(ADDR_W'($urandom_range(0, STORE_DEPTH - 1)), SAMPLE_W'($urandom));
            end else if (choice < 17) begin
                repeat ($urandom_range(1, 20)) send_tick();
            end else if (choice < 19) begin
                send_noise();
            end else begin
                wait_all_results(2);
                gaps_on = ($urandom_range(0, 2) != 0);
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_tick_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            ticks_seen++;
            if (expected_ticks.size() == 0) begin
                note_failure($sformatf("result beat with none expected, tdata %h", o_m_tdata));
            end else begin
                want = expected_ticks.pop_front();
                if (o_m_tdata[SAMPLE_W-1:0] !== want.sample
                        || o_m_tdata[SAMPLE_W +: PERIOD_W] !== want.period
                        || o_m_tdata[UPD_BIT] !== want.updated)
                    note_failure($sformatf(
                        "expected sample %0d period %0d updated %0d, got %0d %0d %0d",
                        want.sample, want.period, want.updated, o_m_tdata[SAMPLE_W-1:0],
                        o_m_tdata[SAMPLE_W +: PERIOD_W], o_m_tdata[UPD_BIT]));
            end
        end
    end

    initial begin : result_sink
        int unsigned stall;
        i_m_tready = 1'b0;
        forever begin
            stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall != 0) begin
                @(negedge i_clk) i_m_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk) i_m_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_tvalid !== 1'b1);
        end
    end

    initial begin : watchdog
        #60_000_000;
        $display("decimated_wavetable_oscillator test failed");
        $finish;
    end

    initial begin : main
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = KIND_FREQ;
        gaps_on     = 1'b0;
        last_freq   = '0;
        osc_phase   = '0;
        active_lvl  = '0;
        pending_lvl = '0;
        active_per  = PERIOD_RESET;
        pending_per = PERIOD_RESET;
        held_sample = SAMPLE_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_store_load();
        test_zero_frequency();
        test_level_boundaries();
        test_random_traffic();
        wait_all_results(SETTLE_CYCLES);

        $display("Checked %0d tick beats after %0d frequency updates, %0d of them adopted,",
                 ticks_seen, freq_sent, adoptions);
        $display("and %0d table writes, with ignored beats and idle gaps mixed in.", writes_sent);
        if (mismatches == 0) begin
            $display("decimated_wavetable_oscillator test passed");
        end else begin
            $display("decimated_wavetable_oscillator test failed");
        end
        $finish;
    end

endmodule
